/* sv/assert_macros.svh */
// Assertion macros shared by the cache RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SAWLC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define SAWLC_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define SAWLC_ASSERT(lbl, clk, rstn, prop, msg)

`define SAWLC_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* sv/sawlc_pkg.sv */
// Types, constants and helpers for the set-associative write-back LRU cache.
// No dependencies; used by sawlc_ctrl, sawlc_dp, the top level and the testbench.
package sawlc_pkg;

  localparam int unsigned WAYS      = 4;
  localparam int unsigned SETS      = 16;
  localparam int unsigned WPB       = 4;
  localparam int unsigned WAY_W     = 2;
  localparam int unsigned SET_W     = 4;
  localparam int unsigned OFF_W     = 2;
  localparam int unsigned TAG_W     = 4;
  localparam int unsigned AGE_W     = 2;
  localparam int unsigned ADDR_W    = 10;
  localparam int unsigned LINE_W    = SET_W + WAY_W + OFF_W;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LAT_W     = 14;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned MEM_DEPTH = 1024;
  localparam int unsigned CLR_W     = 11;

  localparam logic [LAT_W-1:0] LAT_MAX = '1;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_kind_e;

  typedef enum logic {
    CFG_READ_LAT  = 1'b0,
    CFG_WRITE_LAT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] word_address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [1:0]        ack_kind;
    logic              hit;
    logic [SET_W-1:0]  set_number;
    logic [LAT_W-1:0]  latency;
    logic [DATA_W-1:0] read_data;
  } rsp_t;

  typedef struct packed {
    logic             idx;
    logic [CFG_W-1:0] data;
  } cfg_t;

  // One tag-RAM row holds the bookkeeping of every way of a set.
  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0]            dirty;
  } row_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RWAIT,
    ST_LOOKUP,
    ST_WB,
    ST_FILL,
    ST_ACC,
    ST_ACC2,
    ST_FINISH,
    ST_FL_RD,
    ST_FL_LOAD,
    ST_FL_PICK,
    ST_FL_WR,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic lookup;
    logic wb;
    logic fill;
    logic xclr;
    logic acc;
    logic acc2;
    logic finish;
    logic fl_load;
    logic fl_pick;
    logic row_wr;
    logic fl_next;
    logic rsp_load;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_flush;
    logic hit_now;
    logic wb_now;
    logic xfer_done;
    logic fl_any;
    logic fl_last;
    logic rsp_free;
  } stat_t;

  // Lowest set bit of a way mask.
  function automatic logic [WAY_W-1:0] first_one(input logic [WAYS-1:0] v);
    logic [WAY_W-1:0] r;
    r = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (v[w]) r = WAY_W'(w);
    end
    return r;
  endfunction

endpackage

/* sv/sawlc_chan_if.sv */
// Valid/ready channel carrying one payload struct.
// Payload type is supplied at instantiation, normally from sawlc_pkg.
interface sawlc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/sawlc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module sawlc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* sv/sawlc_ctrl.sv */
// Sequencer of the cache: one request at a time through lookup, write-back,
// fill, word access and flush walk. Depends on sawlc_pkg.
module sawlc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic [1:0]         req_kind_i,
  output logic               req_ready_o,
  input  sawlc_pkg::stat_t   stat_i,
  output sawlc_pkg::cmd_t    cmd_o
);
  import sawlc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          cmd_o.clr_step = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          case (req_kind_e'(req_kind_i))
            REQ_READ, REQ_WRITE: state_d = ST_RWAIT;
            REQ_FLUSH:           state_d = ST_FL_RD;
            default:             state_d = ST_DONE;
          endcase
        end
      end
      ST_RWAIT: state_d = ST_LOOKUP;
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (stat_i.hit_now)     state_d = ST_ACC;
        else if (stat_i.wb_now) state_d = ST_WB;
        else                    state_d = ST_FILL;
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        if (stat_i.xfer_done) begin
          cmd_o.xclr = 1'b1;
          state_d    = stat_i.is_flush ? ST_FL_PICK : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (stat_i.xfer_done) begin
          cmd_o.xclr = 1'b1;
          state_d    = ST_FINISH;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_ACC2;
      end
      ST_ACC2: begin
        cmd_o.acc2 = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        cmd_o.row_wr = 1'b1;
        state_d      = ST_DONE;
      end
      ST_FL_RD: state_d = ST_FL_LOAD;
      ST_FL_LOAD: begin
        cmd_o.fl_load = 1'b1;
        state_d       = ST_FL_PICK;
      end
      ST_FL_PICK: begin
        if (stat_i.fl_any) begin
          cmd_o.fl_pick = 1'b1;
          state_d       = ST_WB;
        end else begin
          state_d = ST_FL_WR;
        end
      end
      ST_FL_WR: begin
        cmd_o.row_wr = 1'b1;
        if (stat_i.fl_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.fl_next = 1'b1;
          state_d       = ST_FL_RD;
        end
      end
      ST_DONE: begin
        if (stat_i.rsp_free) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

/* sv/sawlc_dp.sv */
// Datapath of the cache: tag/LRU row RAM, line word RAM, backing memory,
// transfer counter, latency accounting and response register. Uses sawlc_pkg.
`include "assert_macros.svh"

module sawlc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sawlc_pkg::req_t    req_data_i,
  input  logic               cfg_we_i,
  input  sawlc_pkg::cfg_t    cfg_data_i,
  input  sawlc_pkg::cmd_t    cmd_i,
  output sawlc_pkg::stat_t   stat_o,
  output logic               rsp_valid_o,
  output sawlc_pkg::rsp_t    rsp_data_o,
  input  logic               rsp_ready_i
);
  import sawlc_pkg::*;

  logic [CFG_W-1:0]             rl_q, wl_q;
  req_t                         req_q;
  row_t                         row_q, row_rd, new_row;
  logic [WAY_W-1:0]             way_q, hit_way, empty_way, lru_way, vic_way, pick_way;
  logic [TAG_W-1:0]             vtag_q;
  logic                         hit_q;
  logic [LAT_W-1:0]             lat_q, lat_miss, lat_sat;
  logic [LAT_W:0]               lat_sum;
  logic [DATA_W-1:0]            rdata_q, word_rdata, mem_rdata, w_wdata, m_wdata;
  logic [CNT_W-1:0]             xcnt_q, xm1;
  logic [SET_W-1:0]             fs_q, set_cur, set_req;
  logic [TAG_W-1:0]             tag_req;
  logic [OFF_W-1:0]             offs, r_off, w_off;
  logic [WAYS-1:0]              dmask_q, vld_set, hit_vec;
  logic [SETS-1:0][WAYS-1:0]    valid_q;
  logic [CLR_W-1:0]             clr_cnt_q;
  rsp_t                         rsp_q;
  logic                         rsp_valid_q;
  req_kind_e                    kind;
  logic                         is_flush, hit_now, full, wb_now, xfer_done, wr_phase;
  logic [AGE_W:0]               old_age;
  logic                         w_we, m_we;
  logic [LINE_W-1:0]            w_raddr, w_waddr;
  logic [ADDR_W-1:0]            m_raddr, m_waddr;

  assign kind     = req_kind_e'(req_q.req_type);
  assign tag_req  = req_q.word_address[ADDR_W-1 -: TAG_W];
  assign set_req  = req_q.word_address[OFF_W +: SET_W];
  assign offs     = req_q.word_address[OFF_W-1:0];
  assign is_flush = (kind == REQ_FLUSH);
  assign set_cur  = is_flush ? fs_q : set_req;
  assign vld_set  = valid_q[set_cur];

  // Lookup against the row read for the current set
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = vld_set[w] && (row_rd.tag[w] == tag_req);
    end
    hit_now   = |hit_vec;
    full      = &vld_set;
    hit_way   = first_one(hit_vec);
    empty_way = first_one(~vld_set);
    lru_way   = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (row_rd.age[w] > row_rd.age[lru_way]) lru_way = WAY_W'(w);
    end
    vic_way = hit_now ? hit_way : (full ? lru_way : empty_way);
    wb_now  = !hit_now && full && row_rd.dirty[lru_way];
    old_age = hit_now ? {1'b0, row_rd.age[hit_way]} : (AGE_W+1)'(WAYS);
    new_row = row_rd;
    for (int w = 0; w < WAYS; w++) begin
      if ((WAY_W'(w) != vic_way) && vld_set[w] && ({1'b0, row_rd.age[w]} < old_age)) begin
        new_row.age[w] = row_rd.age[w] + AGE_W'(1);
      end
    end
    new_row.age[vic_way]   = '0;
    new_row.tag[vic_way]   = tag_req;
    new_row.dirty[vic_way] = (hit_now && row_rd.dirty[vic_way]) || (kind == REQ_WRITE);
    lat_miss = LAT_W'(1) + LAT_W'(rl_q) + (wb_now ? LAT_W'(wl_q) : '0);
  end

  assign pick_way = first_one(dmask_q);
  assign lat_sum  = {1'b0, lat_q} + (LAT_W+1)'(wl_q);
  assign lat_sat  = lat_sum[LAT_W] ? LAT_MAX : lat_sum[LAT_W-1:0];

  // Block transfer: read issued at xcnt, write lands one step behind
  assign xfer_done = (xcnt_q == CNT_W'(WPB));
  assign wr_phase  = (xcnt_q != '0);
  assign xm1       = xcnt_q - CNT_W'(1);

  assign r_off   = cmd_i.acc ? offs : xcnt_q[OFF_W-1:0];
  assign w_off   = cmd_i.acc ? offs : xm1[OFF_W-1:0];
  assign w_raddr = {set_cur, way_q, r_off};
  assign w_waddr = {set_cur, way_q, w_off};
  assign w_we    = (cmd_i.fill && wr_phase) || (cmd_i.acc && kind == REQ_WRITE);
  assign w_wdata = (kind == REQ_WRITE && w_off == offs) ? req_q.write_data : mem_rdata;

  assign m_we    = cmd_i.clr_step || (cmd_i.wb && wr_phase);
  assign m_waddr = cmd_i.clr_step ? clr_cnt_q[ADDR_W-1:0] : {vtag_q, set_cur, xm1[OFF_W-1:0]};
  assign m_wdata = cmd_i.clr_step ? '0 : word_rdata;
  assign m_raddr = {tag_req, set_req, xcnt_q[OFF_W-1:0]};

  sawlc_ram #(.WIDTH($bits(row_t)), .DEPTH(SETS)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.row_wr),
    .waddr_i (set_cur),
    .wdata_i (row_q),
    .raddr_i (set_cur),
    .rdata_o (row_rd)
  );

  sawlc_ram #(.WIDTH(DATA_W), .DEPTH(SETS * WAYS * WPB)) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (word_rdata)
  );

  sawlc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (m_raddr),
    .rdata_o (mem_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_q        <= CFG_W'(1);
      wl_q        <= CFG_W'(1);
      xcnt_q      <= '0;
      valid_q     <= '0;
      clr_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_data_i.idx))
          CFG_READ_LAT:  rl_q <= cfg_data_i.data;
          CFG_WRITE_LAT: wl_q <= cfg_data_i.data;
          default:       rl_q <= rl_q;
        endcase
      end
      if (cmd_i.xclr || cmd_i.lookup || cmd_i.fl_pick) begin
        xcnt_q <= '0;
      end else if ((cmd_i.wb || cmd_i.fill) && !xfer_done) begin
        xcnt_q <= xcnt_q + CNT_W'(1);
      end
      if (cmd_i.finish) valid_q[set_req][way_q] <= 1'b1;
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      if (cmd_i.rsp_load)  rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= req_data_i;
      hit_q   <= 1'b0;
      lat_q   <= '0;
      rdata_q <= '0;
      fs_q    <= '0;
    end
    if (cmd_i.lookup) begin
      row_q  <= new_row;
      way_q  <= vic_way;
      vtag_q <= row_rd.tag[vic_way];
      hit_q  <= hit_now;
      lat_q  <= hit_now ? LAT_W'(1) : lat_miss;
    end
    if (cmd_i.fl_load) begin
      row_q   <= row_rd;
      dmask_q <= vld_set & row_rd.dirty;
    end
    if (cmd_i.fl_pick) begin
      way_q                  <= pick_way;
      vtag_q                 <= row_q.tag[pick_way];
      row_q.dirty[pick_way]  <= 1'b0;
      dmask_q[pick_way]      <= 1'b0;
      lat_q                  <= lat_sat;
    end
    if (cmd_i.fl_next) fs_q <= fs_q + SET_W'(1);
    if (cmd_i.fill && wr_phase && kind == REQ_READ && xm1[OFF_W-1:0] == offs) begin
      rdata_q <= mem_rdata;
    end
    if (cmd_i.acc2 && kind == REQ_READ) rdata_q <= word_rdata;
    if (cmd_i.rsp_load) begin
      rsp_q.ack_kind   <= req_q.req_type;
      rsp_q.hit        <= hit_q;
      rsp_q.set_number <= (kind == REQ_READ || kind == REQ_WRITE) ? set_req : '0;
      rsp_q.latency    <= lat_q;
      rsp_q.read_data  <= rdata_q;
    end
  end

  assign stat_o.clr_done  = clr_cnt_q[CLR_W-1];
  assign stat_o.is_flush  = is_flush;
  assign stat_o.hit_now   = hit_now;
  assign stat_o.wb_now    = wb_now;
  assign stat_o.xfer_done = xfer_done;
  assign stat_o.fl_any    = |dmask_q;
  assign stat_o.fl_last   = (fs_q == SET_W'(SETS - 1));
  assign stat_o.rsp_free  = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_data_o  = rsp_q;

  `SAWLC_ASSERT(a_xcnt_range, clk_i, rst_ni, xcnt_q <= CNT_W'(WPB), "transfer count overran")
  `SAWLC_NEVER(a_wb_fill_excl, clk_i, rst_ni, cmd_i.wb && cmd_i.fill, "write-back and fill overlap")
  `SAWLC_ASSERT(a_clr_sticky, clk_i, rst_ni, clr_cnt_q[CLR_W-1] |=> clr_cnt_q[CLR_W-1], "clear pass restarted")
endmodule

/* sv/set_assoc_writeback_lru_cache.sv */
// Channel  | dir | payload           | notes
// req_i    | in  | sawlc_pkg::req_t  | read, write or flush request
// rsp_o    | out | sawlc_pkg::rsp_t  | one response per request, registered
// cfg_i    | in  | sawlc_pkg::cfg_t  | latency registers, always ready
// One request at a time. A hit passes lookup and word access; a miss passes lookup,
// a write-back when the set is full and its LRU victim is dirty, and a block fill.
// Flush walks the tag rows set by set and writes back each valid dirty line.
// After reset a clearing pass zeroes all 1024 words of backing memory; no request
// is taken meanwhile. A stalled response is held; the next request is still taken.
module set_assoc_writeback_lru_cache (
  input logic           clk_i,
  input logic           rst_ni,
  sawlc_chan_if.sink    req_i,
  sawlc_chan_if.source  rsp_o,
  sawlc_chan_if.sink    cfg_i
);
  import sawlc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  req_ready;
  logic  rsp_valid;
  rsp_t  rsp_data;

  sawlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.payload.req_type),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sawlc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.payload),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.payload),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_valid_o (rsp_valid),
    .rsp_data_o  (rsp_data),
    .rsp_ready_i (rsp_o.ready)
  );

  assign req_i.ready   = req_ready;
  assign cfg_i.ready   = 1'b1;
  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp_data;
endmodule

/* tb/set_assoc_writeback_lru_cache_test.sv */
// Self-checking testbench for set_assoc_writeback_lru_cache: random and directed requests
// are checked against a behavioural cache model. Depends on sawlc_pkg and sawlc_chan_if.
module set_assoc_writeback_lru_cache_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sawlc_pkg::*;

  localparam int unsigned LINES      = SETS * WAYS;
  localparam int unsigned CYCLE_CAP  = 2000000;
  localparam int unsigned DRAIN_WAIT = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sawlc_chan_if #(.payload_t(req_t)) req_ch ();
  sawlc_chan_if #(.payload_t(rsp_t)) rsp_ch ();
  sawlc_chan_if #(.payload_t(cfg_t)) cfg_ch ();

  set_assoc_writeback_lru_cache dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  always #6 clk_i = ~clk_i;

  // Cache model state
  logic             mdl_valid [LINES];
  logic             mdl_dirty [LINES];
  logic [AGE_W-1:0] mdl_age   [LINES];
  logic [3:0]       mdl_tag   [LINES];
  logic [31:0]      mdl_words [LINES*WPB];
  logic [31:0]      mdl_mem   [MEM_DEPTH];
  logic [7:0]       rd_lat;
  logic [7:0]       wr_lat;

  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned cycles;

  function automatic logic [13:0] sat_sum(logic [13:0] a, logic [7:0] b);
    int unsigned s;
    s = a + b;
    return (s > 16383) ? 14'h3fff : 14'(s);
  endfunction

  function automatic void spill_line(int unsigned ln);
    int unsigned start;
    start = (mdl_tag[ln] * SETS + ln / WAYS) * WPB;
    for (int i = 0; i < WPB; i++) mdl_mem[(start + i) % MEM_DEPTH] = mdl_words[ln*WPB + i];
    mdl_dirty[ln] = 1'b0;
  endfunction

  function automatic void promote(int unsigned base, int unsigned ln, int unsigned old_age);
    for (int w = 0; w < WAYS; w++) begin
      if (base + w != ln && mdl_valid[base+w] && mdl_age[base+w] < old_age)
        mdl_age[base+w] = mdl_age[base+w] + 1'b1;
    end
    mdl_age[ln] = '0;
  endfunction

  function automatic rsp_t cache_access(req_t r);
    rsp_t        o;
    req_kind_e   kind;
    int unsigned blk, offs, set, tag, base, ln, start;
    logic        hit, wb, found;
    o = '0;
    kind = req_kind_e'(r.req_type);
    o.ack_kind = r.req_type;
    ln = 0;
    hit = 1'b0;
    wb = 1'b0;
    found = 1'b0;
    if (kind == REQ_UNUSED) return o;
    if (kind == REQ_FLUSH) begin
      for (int l = 0; l < LINES; l++) begin
        if (mdl_valid[l] && mdl_dirty[l]) begin
          spill_line(l);
          o.latency = sat_sum(o.latency, wr_lat);
        end
      end
      return o;
    end
    blk  = r.word_address / WPB;
    offs = r.word_address % WPB;
    set  = blk % SETS;
    tag  = blk / SETS;
    base = set * WAYS;
    o.latency = 14'd1;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && mdl_valid[base+w] && mdl_tag[base+w] == tag) begin
        hit = 1'b1;
        ln = base + w;
      end
    end
    if (hit) begin
      promote(base, ln, mdl_age[ln]);
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !mdl_valid[base+w]) begin
          found = 1'b1;
          ln = base + w;
        end
      end
      if (!found) begin
        // evict the least recent way
        ln = base;
        for (int w = 1; w < WAYS; w++) if (mdl_age[base+w] > mdl_age[ln]) ln = base + w;
        if (mdl_dirty[ln]) begin
          spill_line(ln);
          wb = 1'b1;
        end
        mdl_valid[ln] = 1'b0;
      end
      start = blk * WPB;
      for (int i = 0; i < WPB; i++) mdl_words[ln*WPB + i] = mdl_mem[(start + i) % MEM_DEPTH];
      mdl_tag[ln] = 4'(tag);
      mdl_dirty[ln] = 1'b0;
      promote(base, ln, WAYS);
      mdl_valid[ln] = 1'b1;
      if (wb) o.latency = sat_sum(o.latency, wr_lat);
      o.latency = sat_sum(o.latency, rd_lat);
    end
    if (kind == REQ_READ) begin
      o.read_data = mdl_words[ln*WPB + offs];
    end else begin
      mdl_words[ln*WPB + offs] = r.write_data;
      mdl_dirty[ln] = 1'b1;
    end
    o.hit = hit;
    o.set_number = 4'(set);
    return o;
  endfunction

  // Request driver: predict on acceptance, then offer the next request or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_rsps.insert(expected_rsps.size(), cache_access(req_ch.payload));
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.payload <= pending_reqs.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", rsp_ch.payload);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_ch.payload.ack_kind !== exp_rsp.ack_kind ||
              rsp_ch.payload.hit !== exp_rsp.hit ||
              rsp_ch.payload.set_number !== exp_rsp.set_number ||
              rsp_ch.payload.latency !== exp_rsp.latency ||
              rsp_ch.payload.read_data !== exp_rsp.read_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: expected %p, got %p", exp_rsp, rsp_ch.payload);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_ch.valid) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= '{idx: idx, data: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == CFG_READ_LAT) rd_lat = val;
    else wr_lat = val;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void queue_req(req_kind_e k, logic [9:0] a, logic [31:0] d);
    pending_reqs.insert(pending_reqs.size(), '{req_type: k, word_address: a, write_data: d});
  endfunction

  // Mostly a few hot sets and tags, so that hits, evictions and write-backs all occur
  function automatic void queue_random(int unsigned n);
    int unsigned pick;
    logic [9:0]  a;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(3) == 0) a = 10'($urandom);
      else a = {4'($urandom_range(5)), 4'($urandom_range(2)), 2'($urandom)};
      if (pick < 48) queue_req(REQ_READ, a, $urandom);
      else if (pick < 94) queue_req(REQ_WRITE, a, $urandom);
      else if (pick < 97) queue_req(REQ_FLUSH, a, $urandom);
      else queue_req(REQ_UNUSED, a, $urandom);
    end
  endfunction

  initial begin
    for (int l = 0; l < LINES; l++) begin
      mdl_valid[l] = 1'b0;
      mdl_dirty[l] = 1'b0;
      mdl_age[l] = '0;
      mdl_tag[l] = '0;
    end
    for (int i = 0; i < LINES*WPB; i++) mdl_words[i] = '0;
    for (int i = 0; i < MEM_DEPTH; i++) mdl_mem[i] = '0;
    rd_lat = 8'd1;
    wr_lat = 8'd1;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, LRU eviction with dirty victims, flushes, unused kind
    write_reg(CFG_READ_LAT, 8'd0);
    write_reg(CFG_WRITE_LAT, 8'd255);
    queue_req(REQ_READ, 10'd0, 32'hffff_ffff);
    queue_req(REQ_WRITE, 10'd1023, 32'hffff_ffff);
    queue_req(REQ_READ, 10'd1023, 32'h0);
    queue_req(REQ_WRITE, 10'd0, 32'h0);
    for (int t = 0; t < 6; t++) queue_req(REQ_WRITE, 10'(t * 64 + 1), 32'hA5A5_0000 + t);
    queue_req(REQ_READ, 10'd1, 32'h0);
    queue_req(REQ_READ, 10'd65, 32'h0);
    queue_req(REQ_READ, 10'd512, 32'h0);
    queue_req(REQ_FLUSH, 10'd0, 32'h0);
    queue_req(REQ_FLUSH, 10'd1023, 32'hffff_ffff);
    queue_req(REQ_UNUSED, 10'd1023, 32'hffff_ffff);
    queue_req(REQ_UNUSED, 10'd0, 32'h0);
    queue_req(REQ_READ, 10'd1023, 32'h0);
    queue_req(REQ_WRITE, 10'd2, 32'h5555_aaaa);
    queue_req(REQ_FLUSH, 10'd0, 32'h0);
    wait_idle();

    write_reg(CFG_READ_LAT, 8'd255);
    write_reg(CFG_WRITE_LAT, 8'd0);
    send_idle_pct = 17;
    recv_idle_pct = 46;
    queue_random(350);
    wait_idle();

    write_reg(CFG_READ_LAT, 8'($urandom));
    write_reg(CFG_WRITE_LAT, 8'($urandom));
    send_idle_pct = 46;
    recv_idle_pct = 17;
    queue_random(350);
    wait_idle();

    write_reg(CFG_READ_LAT, 8'd255);
    write_reg(CFG_WRITE_LAT, 8'd255);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(330);
    queue_req(REQ_FLUSH, 10'd0, 32'h0);
    wait_idle();

    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+sv
sv/sawlc_pkg.sv
sv/sawlc_chan_if.sv
sv/sawlc_ram.sv
sv/sawlc_ctrl.sv
sv/sawlc_dp.sv
sv/set_assoc_writeback_lru_cache.sv
tb/set_assoc_writeback_lru_cache_test.sv
